// ----- rtl/fea_pkg.sv -----
// ----------------------------------------------------------------------------
// fea_pkg
// Shared types and constants for the free extent allocator: the extent
// record, result status codes and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package fea_pkg;

    // Size of the single extent that covers everything after reset.
    localparam logic [31:0] SIZE_ALL = 32'hFFFF_FFFF;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_NOFIT = 2'd2;

    // One free extent as held in the list memory.
    typedef struct packed {
        logic [31:0] off;
        logic [31:0] size;
    } t_extent;

    // Streaming mode of the list walker.
    typedef enum logic [1:0] {
        M_NONE,
        M_SCAN,
        M_UP,
        M_DN
    } t_mode;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  start;
        t_mode mode;
        logic  decide;
        logic  count_dec;
        logic  head_write;
        logic  out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic req_free;
        logic full;
        logic exact;
        logic up_done;
        logic dn_done;
    } t_sts;

endpackage

// ----- rtl/fea_ctrl.sv -----
// ----------------------------------------------------------------------------
// fea_ctrl
// Controller of the free extent allocator. Sequences one request through
// routing, list scan, decision, list shift and result hand-off.
// ----------------------------------------------------------------------------
module fea_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    output logic          o_res_valid,
    input  logic          i_res_ready,
    output fea_pkg::t_cmd o_cmd,
    input  fea_pkg::t_sts i_sts
);
    import fea_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROUTE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    t_cmd   cmd;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        cmd.mode = M_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    cmd.start = 1'b1;
                    n_state   = S_ROUTE;
                end
            end
            S_ROUTE: begin
                priority if (i_sts.req_free && i_sts.full) begin
                    n_state = S_FINISH;
                end else if (i_sts.req_free) begin
                    n_state = S_SHIFT_DN;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.mode = M_SCAN;
                if (i_sts.exact || i_sts.up_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                cmd.decide = 1'b1;
                n_state    = i_sts.exact ? S_SHIFT_UP : S_FINISH;
            end
            S_SHIFT_UP: begin
                cmd.mode = M_UP;
                if (i_sts.up_done) begin
                    cmd.count_dec = 1'b1;
                    n_state       = S_FINISH;
                end
            end
            S_SHIFT_DN: begin
                cmd.mode = M_DN;
                if (i_sts.dn_done) begin
                    cmd.head_write = 1'b1;
                    n_state        = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_res_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and output valid register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_cmd       = cmd;
    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = r_out_valid;

endmodule

// ----- rtl/fea_dp.sv -----
// ----------------------------------------------------------------------------
// fea_dp
// Datapath of the free extent allocator: the extent list memory, the
// streaming walker that scans and shifts it, the fit search registers and
// the result register.
// ----------------------------------------------------------------------------
module fea_dp #(
    parameter int FREE_SLOTS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  fea_pkg::t_cmd i_cmd,
    output fea_pkg::t_sts o_sts,
    input  logic          i_req_type,
    input  logic [31:0]   i_req_size,
    input  logic [31:0]   i_req_offset,
    output logic [31:0]   o_alloc_offset,
    output logic [1:0]    o_status,
    output logic [6:0]    o_free_extents
);
    import fea_pkg::*;

    localparam int IW = $clog2(FREE_SLOTS);
    localparam int CW = $clog2(FREE_SLOTS + 1);
    localparam logic [CW-1:0] SLOTS_C = CW'(FREE_SLOTS);

    // List memory and its registered read port.
    t_extent r_mem [FREE_SLOTS];
    t_extent r_q;
    logic    r_rd_init;
    logic    r_init;

    // Walker state.
    logic          r_pv;
    logic [IW-1:0] r_pidx;
    logic [CW-1:0] r_ptr;
    logic [CW-1:0] r_count;

    // Request and search state.
    logic          r_req_type;
    logic [31:0]   r_req_size;
    logic [31:0]   r_req_off;
    logic          r_exact;
    logic [IW-1:0] r_hit_idx;
    logic [31:0]   r_hit_off;
    logic          r_big;
    logic [IW-1:0] r_big_idx;
    logic [31:0]   r_big_off;
    logic [31:0]   r_big_size;
    logic [31:0]   r_res_off;
    logic [1:0]    r_res_st;

    // Output register.
    logic [31:0]   r_out_off;
    logic [1:0]    r_out_st;
    logic [6:0]    r_out_cnt;

    t_extent       rd_data;
    logic          issue;
    logic [CW-1:0] rd_ptr;
    logic [IW-1:0] raddr;
    logic          we;
    logic [IW-1:0] waddr;
    t_extent       wdata;

    // Slot 0 reads as the reset extent until it is first written.
    always_comb begin
        if (r_rd_init) begin
            rd_data.off  = '0;
            rd_data.size = SIZE_ALL;
        end else begin
            rd_data = r_q;
        end
    end

    // Read issue: scan and shift-up walk forward, shift-down walks backward.
    always_comb begin
        unique case (i_cmd.mode)
            M_SCAN:  issue = !r_exact && (r_ptr < r_count);
            M_UP:    issue = (r_ptr < r_count);
            M_DN:    issue = (r_ptr != '0);
            default: issue = 1'b0;
        endcase
        rd_ptr = (i_cmd.mode == M_DN) ? (r_ptr - CW'(1)) : r_ptr;
        raddr  = rd_ptr[IW-1:0];
    end

    // Write port select.
    always_comb begin
        we    = 1'b0;
        waddr = '0;
        wdata = rd_data;
        priority if (i_cmd.mode == M_UP && r_pv) begin
            we    = 1'b1;
            waddr = r_pidx - IW'(1);
        end else if (i_cmd.mode == M_DN && r_pv) begin
            we    = 1'b1;
            waddr = r_pidx + IW'(1);
        end else if (i_cmd.decide && !r_exact && r_big) begin
            we         = 1'b1;
            waddr      = r_big_idx;
            wdata.off  = r_big_off + r_req_size;
            wdata.size = r_big_size - r_req_size;
        end else if (i_cmd.head_write) begin
            we         = 1'b1;
            waddr      = '0;
            wdata.off  = r_req_off;
            wdata.size = r_req_size;
        end else begin
            we = 1'b0;
        end
    end

    // Memory write and registered read.
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (issue) begin
            r_q       <= r_mem[raddr];
            r_rd_init <= (raddr == '0) && r_init;
            r_pidx    <= raddr;
        end
    end

    // Walker, count and search control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init  <= 1'b1;
            r_pv    <= 1'b0;
            r_ptr   <= '0;
            r_count <= CW'(1);
            r_exact <= 1'b0;
            r_big   <= 1'b0;
        end else begin
            if (we && waddr == '0) begin
                r_init <= 1'b0;
            end
            r_pv <= issue;

            if (i_cmd.start) begin
                r_ptr <= i_req_type ? r_count : '0;
            end else if (issue) begin
                r_ptr <= (i_cmd.mode == M_DN) ? (r_ptr - CW'(1)) : (r_ptr + CW'(1));
            end else if (i_cmd.decide && r_exact) begin
                r_ptr <= CW'(r_hit_idx) + CW'(1);
            end

            if (i_cmd.count_dec) begin
                r_count <= r_count - CW'(1);
            end else if (i_cmd.head_write) begin
                r_count <= r_count + CW'(1);
            end

            if (i_cmd.start) begin
                r_exact <= 1'b0;
                r_big   <= 1'b0;
            end else if (i_cmd.mode == M_SCAN && r_pv && !r_exact) begin
                if (rd_data.size == r_req_size) begin
                    r_exact <= 1'b1;
                end
                if (!r_big && rd_data.size > r_req_size) begin
                    r_big <= 1'b1;
                end
            end
        end
    end

    // Request, search payload and result registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_req_type <= i_req_type;
            r_req_size <= i_req_size;
            r_req_off  <= i_req_offset;
            r_res_off  <= '0;
            r_res_st   <= (i_req_type && r_count >= SLOTS_C) ? ST_FULL : ST_OK;
        end else if (i_cmd.decide) begin
            priority if (r_exact) begin
                r_res_off <= r_hit_off;
            end else if (r_big) begin
                r_res_off <= r_big_off;
            end else begin
                r_res_st <= ST_NOFIT;
            end
        end

        if (i_cmd.mode == M_SCAN && r_pv && !r_exact) begin
            if (rd_data.size == r_req_size) begin
                r_hit_idx <= r_pidx;
                r_hit_off <= rd_data.off;
            end
            if (!r_big && rd_data.size > r_req_size) begin
                r_big_idx  <= r_pidx;
                r_big_off  <= rd_data.off;
                r_big_size <= rd_data.size;
            end
        end

        if (i_cmd.out_load) begin
            r_out_off <= r_res_off;
            r_out_st  <= r_res_st;
            r_out_cnt <= 7'(r_count);
        end
    end

    // Status to the controller.
    assign o_sts.req_free = r_req_type;
    assign o_sts.full     = (r_count >= SLOTS_C);
    assign o_sts.exact    = r_exact;
    assign o_sts.up_done  = !r_pv && (r_ptr >= r_count);
    assign o_sts.dn_done  = !r_pv && (r_ptr == '0);

    assign o_alloc_offset = r_out_off;
    assign o_status       = r_out_st;
    assign o_free_extents = r_out_cnt;

endmodule

// ----- rtl/free_extent_allocator_core.sv -----
// ----------------------------------------------------------------------------
// free_extent_allocator_core
// Exact-fit-then-first-fit allocator over an ordered list of free extents.
//
//   Channel   Direction  Handshake                    Payload
//   request   in         i_req_valid / o_req_ready    type, size, offset
//   result    out        o_res_valid / i_res_ready    offset, status, count
//
// One request is in flight at a time. The result is registered after the
// walk over the list memory, one read and, when shifting, one write per
// cycle, so its wait grows with the number of extents held; a free into a
// full list skips the walk.
// Reset is synchronous; afterwards the list holds one extent covering
// everything and requests are taken at once. A result waits in the output
// register while the result side stalls; the next request is taken once the
// current result has moved there.
// ----------------------------------------------------------------------------
module free_extent_allocator_core #(
    parameter int FREE_SLOTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    output logic        o_req_ready,
    input  logic        i_req_type,
    input  logic [31:0] i_req_size,
    input  logic [31:0] i_req_offset,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic [31:0] o_alloc_offset,
    output logic [1:0]  o_status,
    output logic [6:0]  o_free_extents
);
    import fea_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequencing of each request.
    fea_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // List storage and arithmetic.
    fea_dp #(
        .FREE_SLOTS (FREE_SLOTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_req_type     (i_req_type),
        .i_req_size     (i_req_size),
        .i_req_offset   (i_req_offset),
        .o_alloc_offset (o_alloc_offset),
        .o_status       (o_status),
        .o_free_extents (o_free_extents)
    );

endmodule
